// ===== sv/rbsi_pkg.sv =====
// Shared types and constants for the ray versus box slab test.
package rbsi_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned NUM_W   = COORD_W + 1;
	localparam int unsigned FRAC_W  = 16;
	// Divider latency: one set-up stage, one stage per quotient bit, one saturation stage.
	localparam int unsigned DIV_LAT = COORD_W + 2;
	// Full latency from the accepting edge to the strobe being sampled.
	localparam int unsigned TOT_LAT = DIV_LAT + 4;

	localparam logic signed [COORD_W-1:0] Q_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] Q_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef struct packed {
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] origin_z;
		logic signed [COORD_W-1:0] dir_x;
		logic signed [COORD_W-1:0] dir_y;
		logic signed [COORD_W-1:0] dir_z;
		logic signed [COORD_W-1:0] lo_corner_x;
		logic signed [COORD_W-1:0] lo_corner_y;
		logic signed [COORD_W-1:0] lo_corner_z;
		logic signed [COORD_W-1:0] hi_corner_x;
		logic signed [COORD_W-1:0] hi_corner_y;
		logic signed [COORD_W-1:0] hi_corner_z;
	} item_t;

	typedef struct packed {
		logic                      hit;
		logic signed [COORD_W-1:0] entry_distance;
	} result_t;

endpackage

// ===== sv/ray_box_slab_intersection.sv =====
// Top level of the ray versus axis-aligned box slab test.
//
// Use: drive a ray and a box on item and raise start; the item is taken at
// any rising edge with start high and busy low. busy stays low, so one item
// may be transferred in every cycle and items never wait on each other.
// Each item gives one result: done is high for exactly one cycle with hit
// and entry_distance on result. A miss reports entry_distance as zero.
// Throughput is one item per cycle. The pipeline consists of one numerator
// stage, the six slab dividers, each retiring one quotient bit per stage
// (32 stages plus set-up and saturation), followed by one stage of slab
// ordering and two stages of interval narrowing.
// Results come out in the order the items went in. The receiver cannot
// stall, so the pipeline always advances.
// Reset clears every valid bit at once; items in flight are dropped and no
// strobe follows until a new item is transferred.
module ray_box_slab_intersection (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rbsi_pkg::item_t   item,
	output logic              done,
	output rbsi_pkg::result_t result
);
	import rbsi_pkg::*;

	logic                      v_s1;
	logic signed [NUM_W-1:0]   nlo_s1 [0:2];
	logic signed [NUM_W-1:0]   nhi_s1 [0:2];
	logic signed [COORD_W-1:0] dir_s1 [0:2];

	logic [DIV_LAT-1:0]        vld_q;
	logic signed [COORD_W-1:0] tlo [0:2];
	logic signed [COORD_W-1:0] thi [0:2];

	logic                      v_s2;
	logic signed [COORD_W-1:0] near_s2 [0:2];
	logic signed [COORD_W-1:0] far_s2  [0:2];

	logic                      v_s3;
	logic                      hit_s3;
	logic signed [COORD_W-1:0] tmin_s3, tmax_s3, nz_s3, fz_s3;

	logic                      v_s4;
	logic                      hit_s4;
	logic signed [COORD_W-1:0] tmin_s4;

	logic signed [COORD_W-1:0] org [0:2];
	logic signed [COORD_W-1:0] dir [0:2];
	logic signed [COORD_W-1:0] lo  [0:2];
	logic signed [COORD_W-1:0] hi  [0:2];

	assign busy = 1'b0;

	always_comb begin
		org[0] = item.origin_x;    org[1] = item.origin_y;    org[2] = item.origin_z;
		dir[0] = item.dir_x;       dir[1] = item.dir_y;       dir[2] = item.dir_z;
		lo[0]  = item.lo_corner_x; lo[1]  = item.lo_corner_y; lo[2]  = item.lo_corner_z;
		hi[0]  = item.hi_corner_x; hi[1]  = item.hi_corner_y; hi[2]  = item.hi_corner_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			vld_q <= '0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
		end else begin
			v_s1  <= start && !busy;
			vld_q <= {vld_q[DIV_LAT-2:0], v_s1};
			v_s2  <= vld_q[DIV_LAT-1];
			v_s3  <= v_s2;
			v_s4  <= v_s3;
		end
	end

	// exact 33-bit numerators
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			nlo_s1[a] <= NUM_W'(lo[a]) - NUM_W'(org[a]);
			nhi_s1[a] <= NUM_W'(hi[a]) - NUM_W'(org[a]);
			dir_s1[a] <= dir[a];
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_axis
		rbsi_slab_div u_div_lo (.clk(clk), .num(nlo_s1[a]), .dir(dir_s1[a]), .quot(tlo[a]));
		rbsi_slab_div u_div_hi (.clk(clk), .num(nhi_s1[a]), .dir(dir_s1[a]), .quot(thi[a]));
	end

	// order each slab pair; swap only when strictly greater
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			near_s2[a] <= (tlo[a] > thi[a]) ? thi[a] : tlo[a];
			far_s2[a]  <= (tlo[a] > thi[a]) ? tlo[a] : thi[a];
		end
	end

	// narrow by the y slab
	always_ff @(posedge clk) begin
		hit_s3  <= !(near_s2[0] > far_s2[1] || near_s2[1] > far_s2[0]);
		tmin_s3 <= (near_s2[1] > near_s2[0]) ? near_s2[1] : near_s2[0];
		tmax_s3 <= (far_s2[1] < far_s2[0]) ? far_s2[1] : far_s2[0];
		nz_s3   <= near_s2[2];
		fz_s3   <= far_s2[2];
	end

	// narrow by the z slab
	always_ff @(posedge clk) begin
		hit_s4  <= hit_s3 && !(tmin_s3 > fz_s3 || nz_s3 > tmax_s3);
		tmin_s4 <= (nz_s3 > tmin_s3) ? nz_s3 : tmin_s3;
	end

	assign done                  = v_s4;
	assign result.hit            = hit_s4;
	assign result.entry_distance = hit_s4 ? tmin_s4 : '0;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n, TOT_LAT) |-> done == $past(start, TOT_LAT))
		else $error("result strobe out of step with transferred items");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.hit |-> result.entry_distance == '0)
		else $error("miss with non-zero entry distance");

	a_zero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[DIV_LAT-1] && $past(dir_s1[0] == '0, DIV_LAT) |->
		(tlo[0] == Q_MAX || tlo[0] == Q_MIN))
		else $error("zero direction did not saturate");

	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[DIV_LAT-1] && $past(!nlo_s1[0][NUM_W-1] && !dir_s1[0][COORD_W-1], DIV_LAT)
		|-> !tlo[0][COORD_W-1])
		else $error("non-negative quotient came out negative");

endmodule

// ===== sv/rbsi_slab_div.sv =====
// Pipelined saturating Q16.16 divider: one slab distance, one quotient bit per stage.
module rbsi_slab_div (
	input  logic                                 clk,
	input  logic signed [rbsi_pkg::NUM_W-1:0]    num,
	input  logic signed [rbsi_pkg::COORD_W-1:0]  dir,
	output logic signed [rbsi_pkg::COORD_W-1:0]  quot
);
	import rbsi_pkg::*;

	localparam int unsigned DVD_W = NUM_W + FRAC_W;

	logic [NUM_W-1:0]   num_mag;
	logic [COORD_W-1:0] dir_mag;
	logic [DVD_W-1:0]   dvd;
	logic               ovf;

	logic [COORD_W-1:0] rem_s  [0:COORD_W];
	logic [COORD_W-1:0] low_s  [0:COORD_W];
	logic [COORD_W-1:0] dmag_s [0:COORD_W];
	logic [COORD_W-1:0] quo_s  [0:COORD_W];
	logic               neg_s  [0:COORD_W];
	logic               zero_s [0:COORD_W];
	logic               nneg_s [0:COORD_W];
	logic               ovf_s  [0:COORD_W];

	always_comb begin
		num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		dir_mag = dir[COORD_W-1] ? COORD_W'(-dir) : COORD_W'(dir);
		dvd     = {num_mag, {FRAC_W{1'b0}}};
		// quotient of 2^32 or more: the top bits of the dividend already reach the divisor
		ovf     = {{(COORD_W-(DVD_W-COORD_W)){1'b0}}, dvd[DVD_W-1:COORD_W]} >= dir_mag;
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= {{(COORD_W-(DVD_W-COORD_W)){1'b0}}, dvd[DVD_W-1:COORD_W]};
		low_s[0]  <= dvd[COORD_W-1:0];
		dmag_s[0] <= dir_mag;
		quo_s[0]  <= '0;
		neg_s[0]  <= num[NUM_W-1] ^ dir[COORD_W-1];
		zero_s[0] <= (dir == '0);
		nneg_s[0] <= !num[NUM_W-1];
		ovf_s[0]  <= ovf;
	end

	for (genvar k = 0; k < COORD_W; k++) begin : g_step
		logic [COORD_W:0] trial;
		logic [COORD_W:0] diff;
		logic             ge;

		always_comb begin
			trial = {rem_s[k], low_s[k][COORD_W-1]};
			diff  = trial - {1'b0, dmag_s[k]};
			ge    = trial >= {1'b0, dmag_s[k]};
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
			low_s[k+1]  <= {low_s[k][COORD_W-2:0], 1'b0};
			dmag_s[k+1] <= dmag_s[k];
			quo_s[k+1]  <= {quo_s[k][COORD_W-2:0], ge};
			neg_s[k+1]  <= neg_s[k];
			zero_s[k+1] <= zero_s[k];
			nneg_s[k+1] <= nneg_s[k];
			ovf_s[k+1]  <= ovf_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (zero_s[COORD_W]) begin
			quot <= nneg_s[COORD_W] ? Q_MAX : Q_MIN;
		end else if (neg_s[COORD_W]) begin
			if (ovf_s[COORD_W] || quo_s[COORD_W] > COORD_W'(Q_MIN))
				quot <= Q_MIN;
			else
				quot <= COORD_W'(-quo_s[COORD_W]);
		end else begin
			if (ovf_s[COORD_W] || quo_s[COORD_W][COORD_W-1])
				quot <= Q_MAX;
			else
				quot <= quo_s[COORD_W];
		end
	end

endmodule
